FILE: rtl/skhf_pkg.sv
// ----------------------------------------------------------------------------
// skhf_pkg: shared types and constants for the spatial key hash table
// Holds the table geometry, hash multipliers, status codes, word types and
// the command/status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package skhf_pkg;

   // Table geometry. The table has 2^INDEX_BITS slots.
   localparam int INDEX_BITS  = 10;
   localparam int TABLE_DEPTH = 1 << INDEX_BITS;

   // Fixed field widths.
   localparam int KEY_W    = 40;
   localparam int ID_W     = 10;
   localparam int CNT_W    = 11;
   localparam int STATUS_W = 3;
   localparam int ENTRY_W  = 1 + 3 * KEY_W + ID_W;

   // Ids never exceed this count, whatever the limit register holds.
   localparam logic [CNT_W-1:0] ID_CAP          = 11'd1024;
   localparam logic [CNT_W-1:0] MAX_SITES_RESET = 11'd1024;

   // Only the low INDEX_BITS of each product reach the slot index, and those
   // depend only on the low INDEX_BITS of the key and of the multiplier.
   localparam logic [INDEX_BITS-1:0] MUL_X = INDEX_BITS'(32'd73856093);
   localparam logic [INDEX_BITS-1:0] MUL_Y = INDEX_BITS'(32'd19349663);
   localparam logic [INDEX_BITS-1:0] MUL_Z = INDEX_BITS'(32'd83492791);

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LIMIT     = 3'd4;

   // Command codes on the request word.
   localparam logic CMD_FIND   = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   // Which key the shared hash multiplier works on.
   localparam logic [1:0] HSEL_X = 2'd0;
   localparam logic [1:0] HSEL_Y = 2'd1;
   localparam logic [1:0] HSEL_Z = 2'd2;

   typedef struct packed {
      logic                    cmd;
      logic signed [KEY_W-1:0] key_x;
      logic signed [KEY_W-1:0] key_y;
      logic signed [KEY_W-1:0] key_z;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     site_id;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // One table slot as it sits in the memory.
   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] key_x;
      logic [KEY_W-1:0] key_y;
      logic [KEY_W-1:0] key_z;
      logic [ID_W-1:0]  site_id;
   } entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic                load_req;
      logic                hash_step;
      logic [1:0]          hash_sel;
      logic                clear_write;
      logic                probe_start;
      logic                probe_next;
      logic                insert_write;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_last;
      logic slot_empty;
      logic key_match;
      logic sweep_last;
      logic is_insert;
      logic limit_hit;
   } dp_stat_type;

endpackage

FILE: rtl/spatial_key_hash_find_or_insert_top.sv
// ----------------------------------------------------------------------------
// spatial_key_hash_find_or_insert_top: 3D key to dense site id hash table
// Open-addressing table with linear probing that finds, or finds and
// inserts, a quantized 3D position key and returns its site id.
// ----------------------------------------------------------------------------
// A request word is taken at a clock edge where start is high and busy is
// low; its result word appears on rsp_word for exactly one cycle, marked by
// rsp_valid, and cannot be held off. After reset the block is busy while it
// marks every slot empty, one slot at a time; limit register writes are
// taken during that time as always. Each request then runs through three
// hash steps, whose three key products share one multiplier, a step that
// issues the first slot memory read, and a probe walk over 1 to 1024
// slots, one slot at a time, as the slot memory has a single read port.
// The block takes no new request until that is done. The result strobe
// shows in the first cycle in which busy is low again, so a new request
// can be taken in that same cycle.
//
// The home slot is the XOR of the three key-times-constant products, cut to
// the table index width; probing walks upward and wraps. A find stops on a
// matching key or on an empty slot. A find-or-insert claims the first empty
// slot and gives it the next id, unless the id count has reached the limit
// register (capped at 1024), in which case the table is left unchanged and
// the id limit status is returned. A sweep of the whole table with neither
// a match nor an empty slot returns not found for a find and table full for
// an insert. The site id is zero for every status other than found and
// inserted. The limit register should be written only while the block is
// idle.
// ----------------------------------------------------------------------------
module spatial_key_hash_find_or_insert_top (
   input  logic                       clock,
   input  logic                       reset,

   // Request word.
   input  logic                       start,
   output logic                       busy,
   input  skhf_pkg::req_type          req_word,

   // Result word.
   output logic                       rsp_valid,
   output skhf_pkg::rsp_type          rsp_word,

   // Id limit register.
   input  logic                       csr_wr_en,
   input  logic [skhf_pkg::CNT_W-1:0] csr_wr_data
);
   import skhf_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // The controller only sequences; every register of the table, the hash
   // and the result word lives in the datapath.
   skhf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   skhf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req         (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp_word)
   );

endmodule

FILE: rtl/skhf_ram.sv
// ----------------------------------------------------------------------------
// skhf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module skhf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/skhf_datapath.sv
// ----------------------------------------------------------------------------
// skhf_datapath: key registers, hash unit, probe pointer and slot memory
// Carries out the commands of the controller and reports slot conditions.
// ----------------------------------------------------------------------------
module skhf_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  skhf_pkg::req_type              req,
   input  logic                           csr_wr_en,
   input  logic [skhf_pkg::CNT_W-1:0]     csr_wr_data,
   input  skhf_pkg::ctrl_cmd_type         cmd,
   output skhf_pkg::dp_stat_type          stat,
   output logic                           rsp_valid,
   output skhf_pkg::rsp_type              rsp
);
   import skhf_pkg::*;

   // Latched request and hash state.
   req_type               req_ff, req_in;
   logic [INDEX_BITS-1:0] hash_ff, hash_in;
   logic [INDEX_BITS-1:0] key_lo;
   logic [INDEX_BITS-1:0] mul_lo;
   logic [INDEX_BITS-1:0] hash_prod;

   // Probe pointer and sweep counter.
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [INDEX_BITS-1:0] probe_cnt_ff, probe_cnt_in;

   // Clearing pass address.
   logic [INDEX_BITS-1:0] clr_ff, clr_in;

   // Id allocation and limit.
   logic [CNT_W-1:0] next_id_ff, next_id_in;
   logic [CNT_W-1:0] max_sites_ff, max_sites_in;
   logic [CNT_W-1:0] limit;

   // Result word.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Memory ports.
   logic                  ram_we;
   logic [INDEX_BITS-1:0] ram_waddr;
   entry_type             ram_wentry;
   logic [ENTRY_W-1:0]    ram_rdata;
   entry_type             rentry;

   // Shared hash multiplier: one key per cycle, products folded by XOR.
   always_comb begin
      unique case (cmd.hash_sel)
         HSEL_X: begin
            key_lo = req_ff.key_x[INDEX_BITS-1:0];
            mul_lo = MUL_X;
         end
         HSEL_Y: begin
            key_lo = req_ff.key_y[INDEX_BITS-1:0];
            mul_lo = MUL_Y;
         end
         HSEL_Z: begin
            key_lo = req_ff.key_z[INDEX_BITS-1:0];
            mul_lo = MUL_Z;
         end
         default: begin
            key_lo = '0;
            mul_lo = '0;
         end
      endcase
   end

   assign hash_prod = key_lo * mul_lo;

   always_comb begin
      req_in  = req_ff;
      hash_in = hash_ff;
      if (cmd.load_req) begin
         req_in  = req;
         hash_in = '0;
      end else if (cmd.hash_step) begin
         hash_in = hash_ff ^ hash_prod;
      end
   end

   // The read address is the next pointer value, so the registered slot data
   // lines up with idx_ff.
   always_comb begin
      idx_in       = idx_ff;
      probe_cnt_in = probe_cnt_ff;
      if (cmd.probe_start) begin
         idx_in       = hash_ff;
         probe_cnt_in = '0;
      end else if (cmd.probe_next) begin
         idx_in       = INDEX_BITS'(idx_ff + 1'b1);
         probe_cnt_in = INDEX_BITS'(probe_cnt_ff + 1'b1);
      end
   end

   assign clr_in = cmd.clear_write ? INDEX_BITS'(clr_ff + 1'b1) : clr_ff;

   assign limit = (max_sites_ff > ID_CAP) ? ID_CAP : max_sites_ff;

   assign max_sites_in = csr_wr_en ? csr_wr_data : max_sites_ff;
   assign next_id_in   = cmd.insert_write ? CNT_W'(next_id_ff + 1'b1) : next_id_ff;

   // Memory write: a cleared slot during the reset pass, or a claimed slot.
   always_comb begin
      ram_we     = cmd.clear_write | cmd.insert_write;
      ram_waddr  = idx_ff;
      ram_wentry = '0;
      if (cmd.clear_write) begin
         ram_waddr = clr_ff;
      end else begin
         ram_wentry.used    = 1'b1;
         ram_wentry.key_x   = req_ff.key_x;
         ram_wentry.key_y   = req_ff.key_y;
         ram_wentry.key_z   = req_ff.key_z;
         ram_wentry.site_id = next_id_ff[ID_W-1:0];
      end
   end

   skhf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wentry),
      .rd_addr (idx_in),
      .rd_data (ram_rdata)
   );

   assign rentry = entry_type'(ram_rdata);

   always_comb begin
      stat.clear_last = (clr_ff == {INDEX_BITS{1'b1}});
      stat.slot_empty = !rentry.used;
      stat.key_match  = rentry.used
                        && (rentry.key_x == req_ff.key_x)
                        && (rentry.key_y == req_ff.key_y)
                        && (rentry.key_z == req_ff.key_z);
      stat.sweep_last = (probe_cnt_ff == {INDEX_BITS{1'b1}});
      stat.is_insert  = (req_ff.cmd == CMD_INSERT);
      stat.limit_hit  = (next_id_ff >= limit);
   end

   // The id is reported only for a hit or a fresh insert.
   always_comb begin
      rsp_valid_in   = cmd.rsp_load;
      rsp_in         = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.status = cmd.rsp_status;
         priority if (cmd.rsp_status == ST_FOUND) begin
            rsp_in.site_id = rentry.site_id;
         end else if (cmd.rsp_status == ST_INSERTED) begin
            rsp_in.site_id = next_id_ff[ID_W-1:0];
         end else begin
            rsp_in.site_id = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         next_id_ff   <= '0;
         max_sites_ff <= MAX_SITES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         next_id_ff   <= next_id_in;
         max_sites_ff <= max_sites_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      hash_ff      <= hash_in;
      idx_ff       <= idx_in;
      probe_cnt_ff <= probe_cnt_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/skhf_ctrl.sv
// ----------------------------------------------------------------------------
// skhf_ctrl: sequencing state machine for the hash table
// Runs the clearing pass, the three hash steps and the probe walk.
// ----------------------------------------------------------------------------
module skhf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  skhf_pkg::dp_stat_type  stat,
   output skhf_pkg::ctrl_cmd_type cmd
);
   import skhf_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HASH_X = 3'd2;
   localparam logic [2:0] S_HASH_Y = 3'd3;
   localparam logic [2:0] S_HASH_Z = 3'd4;
   localparam logic [2:0] S_READ   = 3'd5;
   localparam logic [2:0] S_PROBE  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_HASH_X;
            end
         end
         S_HASH_X: begin
            cmd.hash_step = 1'b1;
            cmd.hash_sel  = HSEL_X;
            state_in      = S_HASH_Y;
         end
         S_HASH_Y: begin
            cmd.hash_step = 1'b1;
            cmd.hash_sel  = HSEL_Y;
            state_in      = S_HASH_Z;
         end
         S_HASH_Z: begin
            cmd.hash_step = 1'b1;
            cmd.hash_sel  = HSEL_Z;
            state_in      = S_READ;
         end
         S_READ: begin
            cmd.probe_start = 1'b1;
            state_in        = S_PROBE;
         end
         S_PROBE: begin
            priority if (stat.slot_empty) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
               priority if (!stat.is_insert) begin
                  cmd.rsp_status = ST_NOT_FOUND;
               end else if (stat.limit_hit) begin
                  cmd.rsp_status = ST_LIMIT;
               end else begin
                  cmd.rsp_status   = ST_INSERTED;
                  cmd.insert_write = 1'b1;
               end
            end else if (stat.key_match) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_FOUND;
               state_in       = S_IDLE;
            end else if (stat.sweep_last) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = stat.is_insert ? ST_FULL : ST_NOT_FOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
